/* design/hamd_pkg.sv */
// Shared constants and types for the head-angle to mouse-delta block.
// No dependencies; used by every design file but hamd_checker.
package hamd_pkg;

    localparam int ANGLE_FRAC_BITS = 8;
    localparam int DEG_SHIFT       = 29 - ANGLE_FRAC_BITS;
    localparam int PIX_SHIFT       = ANGLE_FRAC_BITS + 8;

    localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
    localparam int HALF_TURN = 180 << ANGLE_FRAC_BITS;
    localparam int ACC_LIMIT = 100 << ANGLE_FRAC_BITS;
    localparam int ACC_MAX   = (1 << (ANGLE_FRAC_BITS + 9)) - 1;
    localparam int ACC_MIN   = -(1 << (ANGLE_FRAC_BITS + 9));

    localparam logic signed [23:0] DEG_PER_RAD = 24'sd3754936;  // 180/pi, Q16
    localparam logic signed [19:0] RAD_PER_DEG = 20'sd292818;   // pi/180, Q24

    localparam int DIV_STEPS = 32;

    typedef enum logic [2:0] {
        REG_MOUSE_EMULATION = 3'd0,
        REG_YAW_GAIN        = 3'd1,
        REG_PITCH_GAIN      = 3'd2,
        REG_ROLL_GAIN       = 3'd3,
        REG_YAW_OFFSET      = 3'd4,
        REG_X_OFFSET        = 3'd5,
        REG_Y_OFFSET        = 3'd6,
        REG_Z_OFFSET        = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic load_in;
        logic conv;
        logic wrap;
        logic accum;
        logic pixels;
        logic div_start;
        logic div_sel;     // 0 yaw, 1 pitch
        logic div_apply;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_ok;
        logic emulation;
        logic px_yaw_zero;
        logic px_pitch_zero;
        logic div_done;
        logic out_free;
    } ctrl_stat_t;

endpackage

/* design/hamd_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on hamd_pkg.
module hamd_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [15:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [17:0] trial;

    always_comb begin
        trial     = {1'b0, rem_reg, quo_reg[31]} - {2'b00, div_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            div_next = divisor;
            cnt_next = 6'(hamd_pkg::DIV_STEPS);
        end else if (cnt_reg != '0) begin
            rem_next = trial[17] ? {rem_reg[14:0], quo_reg[31]} : trial[15:0];
            quo_next = {quo_reg[30:0], ~trial[17]};
            cnt_next = cnt_reg - 6'd1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/hamd_ctrl.sv */
// Sequencer for one tracker request: convert, wrap, accumulate and output; with emulation
// on, pixels and divides come before output. Depends on hamd_pkg.
module hamd_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  hamd_pkg::ctrl_stat_t   stat,
    output hamd_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MUL   = 10'b0000000010,
        S_WRAP  = 10'b0000000100,
        S_ACC   = 10'b0000001000,
        S_PIX   = 10'b0000010000,
        S_DIVY  = 10'b0000100000,
        S_WAITY = 10'b0001000000,
        S_DIVP  = 10'b0010000000,
        S_WAITP = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                if (s_tvalid && stat.in_ok) state_next = S_MUL;
            end
            S_MUL: begin
                cmd.conv   = 1'b1;
                state_next = S_WRAP;
            end
            S_WRAP: begin
                cmd.wrap   = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.accum  = 1'b1;
                state_next = stat.emulation ? S_PIX : S_OUT;
            end
            S_PIX: begin
                cmd.pixels = 1'b1;
                state_next = S_DIVY;
            end
            S_DIVY: begin
                if (stat.px_yaw_zero) begin
                    state_next = S_DIVP;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_WAITY;
                end
            end
            S_WAITY: begin
                if (stat.div_done) begin
                    cmd.div_apply = 1'b1;
                    state_next    = S_DIVP;
                end
            end
            S_DIVP: begin
                cmd.div_sel = 1'b1;
                if (stat.px_pitch_zero) begin
                    state_next = S_OUT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_WAITP;
                end
            end
            S_WAITP: begin
                cmd.div_sel = 1'b1;
                if (stat.div_done) begin
                    cmd.div_apply = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

endmodule

/* design/hamd_dp.sv */
// Datapath: config registers, angle conversion, accumulators, pixel split, output register.
// Depends on hamd_pkg and hamd_div.
module hamd_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hamd_pkg::ctrl_cmd_t   cmd,
    output hamd_pkg::ctrl_stat_t  stat,
    input  logic                  s_tuser,
    input  logic [143:0]          s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  m_tuser,
    output logic [167:0]          m_tdata,
    input  logic                  cfg_valid,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    // configuration
    logic               emu_reg;
    logic [15:0]        yaw_gain_reg, pitch_gain_reg;
    logic signed [15:0] roll_gain_reg;
    logic [16:0]        yaw_off_reg;
    logic signed [31:0] x_off_reg, y_off_reg, z_off_reg;

    // request
    logic signed [15:0] yaw_rad_reg, pitch_rad_reg, roll_rad_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, pos_z_reg;

    // stages
    logic signed [39:0] yaw_prod_reg, pitch_prod_reg;
    logic signed [31:0] rg_prod_reg;
    logic signed [51:0] roll_prod_reg;
    logic [16:0]        yaw_reg;
    logic signed [16:0] pitch_reg;
    logic [16:0]        last_yaw_reg;
    logic signed [16:0] last_pitch_reg;
    logic signed [17:0] yaw_acc_reg, pitch_acc_reg;
    logic signed [15:0] px_yaw_reg, px_pitch_reg;

    // output register
    logic               m_tvalid_reg;
    logic               mv_reg;
    logic [167:0]       m_data_reg;

    // divider
    logic               div_done;
    logic [31:0]        div_quo;
    logic signed [15:0] div_px;
    logic [16:0]        div_abs;

    function automatic logic signed [18:0] deg_of(input logic signed [39:0] p);
        logic signed [39:0] r;
        begin
            r = p + (40'sd1 <<< (hamd_pkg::DEG_SHIFT - 1));
            deg_of = 19'(r >>> hamd_pkg::DEG_SHIFT);
        end
    endfunction

    function automatic logic signed [18:0] wrap_pos(input logic signed [18:0] d);
        wrap_pos = (d < 0) ? d + 19'(hamd_pkg::FULL_TURN) : d;
    endfunction

    function automatic logic signed [18:0] ang_diff(input logic signed [18:0] d);
        if (d > 19'sd0 + 19'(hamd_pkg::HALF_TURN))      ang_diff = d - 19'(hamd_pkg::FULL_TURN);
        else if (d < -19'(hamd_pkg::HALF_TURN))        ang_diff = d + 19'(hamd_pkg::FULL_TURN);
        else                                           ang_diff = d;
    endfunction

    // saturate, then clear when the wrapped angle is beyond the limit
    function automatic logic signed [17:0] limit_acc(input logic signed [17:0] a,
                                                     input logic signed [18:0] d);
        logic signed [19:0] s;
        logic signed [17:0] t;
        logic signed [19:0] w;
        begin
            s = 20'(a) + 20'(d);
            if (s > 20'sd0 + 20'(hamd_pkg::ACC_MAX))      t = 18'(hamd_pkg::ACC_MAX);
            else if (s < 20'(hamd_pkg::ACC_MIN))          t = 18'(hamd_pkg::ACC_MIN);
            else                                          t = 18'(s);
            w = 20'(t) + 20'(hamd_pkg::HALF_TURN);
            if (w < 0)                                    w = w + 20'(hamd_pkg::FULL_TURN);
            else if (w >= 20'(hamd_pkg::FULL_TURN))       w = w - 20'(hamd_pkg::FULL_TURN);
            w = w - 20'(hamd_pkg::HALF_TURN);
            if (w > 20'(hamd_pkg::ACC_LIMIT) || w < -20'(hamd_pkg::ACC_LIMIT)) limit_acc = '0;
            else                                          limit_acc = t;
        end
    endfunction

    // acc * gain, truncated toward zero to whole pixels, saturated
    function automatic logic signed [15:0] pix_of(input logic signed [17:0] a,
                                                  input logic [15:0] g);
        logic signed [34:0] p;
        logic [34:0]        m;
        logic [18:0]        sh;
        begin
            p  = a * $signed({1'b0, g});
            m  = p[34] ? 35'(-p) : 35'(p);
            sh = 19'(m >> hamd_pkg::PIX_SHIFT);
            if (p[34]) pix_of = (sh > 19'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, sh}));
            else       pix_of = (sh > 19'd32767) ? 16'sh7FFF : 16'(sh);
        end
    endfunction

    function automatic logic signed [17:0] acc_sub(input logic signed [17:0] a,
                                                   input logic signed [15:0] px,
                                                   input logic [31:0] q);
        logic signed [18:0] qs;
        begin
            qs = px[15] ? -$signed({1'b0, q[17:0]}) : $signed({1'b0, q[17:0]});
            acc_sub = 18'(19'(a) - qs);
        end
    endfunction

    function automatic logic [31:0] sat_sub32(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
        logic signed [32:0] d;
        begin
            d = 33'(a) - 33'(b);
            if (d > 33'sh0_7FFF_FFFF)       sat_sub32 = 32'h7FFF_FFFF;
            else if (d < -33'sh0_8000_0000) sat_sub32 = 32'h8000_0000;
            else                            sat_sub32 = d[31:0];
        end
    endfunction

    logic signed [18:0] yaw_deg, pitch_deg, pitch_pos, pitch_neg;
    logic signed [18:0] yaw_d, pitch_d, adj_yaw_d;
    logic signed [51:0] roll_rnd;
    logic signed [19:0] roll_sh;
    logic [16:0]        sroll;
    logic [17:0]        adj_yaw;

    always_comb begin
        yaw_deg   = wrap_pos(deg_of(yaw_prod_reg));
        pitch_deg = deg_of(pitch_prod_reg);
        pitch_pos = wrap_pos(pitch_deg);
        pitch_neg = -pitch_pos;
        if (pitch_neg < -19'(hamd_pkg::HALF_TURN)) pitch_neg = pitch_neg + 19'(hamd_pkg::FULL_TURN);

        yaw_d   = ang_diff($signed({2'b00, yaw_reg}) - $signed({2'b00, last_yaw_reg}));
        pitch_d = ang_diff(19'(pitch_reg) - 19'(last_pitch_reg));

        roll_rnd = roll_prod_reg + (52'sd1 <<< 31);
        roll_sh  = 20'(roll_rnd >>> 32);
        if (roll_sh > 20'sd65535)       sroll = 17'h0FFFF;
        else if (roll_sh < -20'sd65536) sroll = 17'h10000;
        else                            sroll = roll_sh[16:0];

        adj_yaw_d = $signed({2'b00, yaw_reg}) - $signed({2'b00, yaw_off_reg});
        if (adj_yaw_d > 19'sd131071)       adj_yaw = 18'h1FFFF;
        else if (adj_yaw_d < -19'sd131072) adj_yaw = 18'h20000;
        else                               adj_yaw = adj_yaw_d[17:0];

        div_px  = cmd.div_sel ? px_pitch_reg : px_yaw_reg;
        div_abs = div_px[15] ? 17'(-$signed({div_px[15], div_px})) : {1'b0, div_px};
    end

    hamd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend ({div_abs[15:0], 16'h0000}),
        .divisor  (cmd.div_sel ? pitch_gain_reg : yaw_gain_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emu_reg        <= 1'b0;
            yaw_gain_reg   <= 16'd256;
            pitch_gain_reg <= 16'd256;
            roll_gain_reg  <= 16'sd256;
            yaw_off_reg    <= '0;
            x_off_reg      <= '0;
            y_off_reg      <= '0;
            z_off_reg      <= '0;
        end else if (cfg_valid) begin
            unique case (hamd_pkg::reg_index_t'(cfg_index))
                hamd_pkg::REG_MOUSE_EMULATION: emu_reg        <= cfg_data[0];
                hamd_pkg::REG_YAW_GAIN:        yaw_gain_reg   <= cfg_data[15:0];
                hamd_pkg::REG_PITCH_GAIN:      pitch_gain_reg <= cfg_data[15:0];
                hamd_pkg::REG_ROLL_GAIN:       roll_gain_reg  <= cfg_data[15:0];
                hamd_pkg::REG_YAW_OFFSET:      yaw_off_reg    <= cfg_data[16:0];
                hamd_pkg::REG_X_OFFSET:        x_off_reg      <= cfg_data;
                hamd_pkg::REG_Y_OFFSET:        y_off_reg      <= cfg_data;
                hamd_pkg::REG_Z_OFFSET:        z_off_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_yaw_reg   <= '0;
            last_pitch_reg <= '0;
            yaw_acc_reg    <= '0;
            pitch_acc_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cmd.accum) begin
                last_yaw_reg   <= yaw_reg;
                last_pitch_reg <= pitch_reg;
                yaw_acc_reg    <= emu_reg ? limit_acc(yaw_acc_reg, yaw_d) : '0;
                pitch_acc_reg  <= emu_reg ? limit_acc(pitch_acc_reg, pitch_d) : '0;
            end
            if (cmd.div_apply) begin
                if (cmd.div_sel) pitch_acc_reg <= acc_sub(pitch_acc_reg, px_pitch_reg, div_quo);
                else             yaw_acc_reg   <= acc_sub(yaw_acc_reg, px_yaw_reg, div_quo);
            end
            if (cmd.load_out)  m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            yaw_rad_reg   <= s_tdata[15:0];
            pitch_rad_reg <= s_tdata[31:16];
            roll_rad_reg  <= s_tdata[47:32];
            pos_x_reg     <= s_tdata[79:48];
            pos_y_reg     <= s_tdata[111:80];
            pos_z_reg     <= s_tdata[143:112];
        end
        if (cmd.conv) begin
            yaw_prod_reg   <= yaw_rad_reg * hamd_pkg::DEG_PER_RAD;
            pitch_prod_reg <= pitch_rad_reg * hamd_pkg::DEG_PER_RAD;
            rg_prod_reg    <= roll_rad_reg * roll_gain_reg;
        end
        if (cmd.wrap) begin
            yaw_reg       <= yaw_deg[16:0];
            pitch_reg     <= pitch_neg[16:0];
            roll_prod_reg <= rg_prod_reg * hamd_pkg::RAD_PER_DEG;
        end
        if (cmd.accum) begin
            px_yaw_reg   <= '0;
            px_pitch_reg <= '0;
        end else if (cmd.pixels) begin
            px_yaw_reg   <= pix_of(yaw_acc_reg, yaw_gain_reg);
            px_pitch_reg <= pix_of(pitch_acc_reg, pitch_gain_reg);
        end
        if (cmd.load_out) begin
            mv_reg     <= emu_reg;
            m_data_reg <= {5'b0, sroll, adj_yaw,
                           sat_sub32(pos_z_reg, z_off_reg),
                           sat_sub32(pos_y_reg, y_off_reg),
                           sat_sub32(pos_x_reg, x_off_reg),
                           px_pitch_reg, px_yaw_reg};
        end
    end

    assign stat.in_ok         = s_tuser;
    assign stat.emulation     = emu_reg;
    assign stat.px_yaw_zero   = (px_yaw_reg == '0);
    assign stat.px_pitch_zero = (px_pitch_reg == '0);
    assign stat.div_done      = div_done;
    assign stat.out_free      = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = mv_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* design/head_angle_to_mouse_delta_top.sv */
// Top level of the head-angle to mouse-delta block: sequencer plus datapath.
// Depends on hamd_pkg, hamd_ctrl, hamd_dp (and hamd_div through hamd_dp).
//
// Takes one tracker request (yaw, pitch, roll in Q13 radians and an x/y/z
// position) and returns one result: mouse pixel deltas, offset-adjusted
// position, adjusted yaw and scaled roll. A request with tracker_ok low (tuser)
// is accepted while the block stays ready and gives no result. Others pass
// through conversion, wrap and accumulation to the output register; with
// emulation on they also pass the pixel split and the shared 32-step serial
// divider, which computes the kept sub-pixel remainder once for yaw and once
// for pitch (skipped for an axis that moves zero pixels). One request is worked
// on at a time; a finished result waits in the output register while the next
// request is accepted, and a stalled result holds the block in its last step.
// Configuration writes are always ready and are meant for when the block is idle.
module head_angle_to_mouse_delta_top (
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tuser,   // tracker_ok
    // yaw_rad[15:0], pitch_rad[31:16], roll_rad[47:32],
    // pos_x[79:48], pos_y[111:80], pos_z[143:112]
    input  logic [143:0] s_tdata,
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic         m_tuser,   // move_valid
    // mouse_dx[15:0], mouse_dy[31:16], adjusted_x[63:32], adjusted_y[95:64],
    // adjusted_z[127:96], adjusted_yaw[145:128], scaled_roll[162:146], zero pad
    output logic [167:0] m_tdata,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    hamd_pkg::ctrl_cmd_t  cmd;
    hamd_pkg::ctrl_stat_t stat;

    assign cfg_ready = 1'b1;

    hamd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hamd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

/* design/hamd_checker.sv */
// Port-level checks for the head-angle to mouse-delta block, bound to the top level.
// Depends on head_angle_to_mouse_delta_top.
module hamd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic         m_tuser,
    input logic [167:0] m_tdata
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // no movement flagged means zero deltas
    a_no_move: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[31:0] == 32'h0)
        else $error("deltas without move_valid");

    // a real sample occupies the block: not ready in the next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("ready right after a sample");

    // an empty sample leaves the block ready
    a_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser |=> s_tready)
        else $error("empty sample stalled the block");

endmodule

bind head_angle_to_mouse_delta_top hamd_checker u_hamd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);

/* tb/head_angle_to_mouse_delta_checker.sv */
// Watches the request, result and config channels of head_angle_to_mouse_delta_top,
// predicts every result and compares it field by field. Depends on hamd_pkg.
`timescale 1ns / 1ps

module head_angle_to_mouse_delta_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic         s_tuser,
    input  logic [143:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic         m_tuser,
    input  logic [167:0] m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           pending
);

    typedef struct {
        logic               move;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [17:0] ayaw;
        logic signed [16:0] roll;
    } motion_t;

    motion_t motion_q[$];

    // shadow registers
    logic               emulation;
    logic [15:0]        yaw_gain, pitch_gain;
    logic signed [15:0] roll_gain;
    logic [16:0]        yaw_offset;
    logic signed [31:0] x_offset, y_offset, z_offset;
    // shadow state
    longint prev_yaw, prev_pitch, yaw_acc, pitch_acc;

    assign pending = motion_q.size();

    function automatic longint clamp(longint v, int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint modulo(longint v, longint m);
        longint r;
        r = v % m;
        return r < 0 ? r + m : r;
    endfunction

    function automatic longint rad_to_deg(logic signed [15:0] rad);
        longint p;
        p = longint'(rad) * 3754936 + (longint'(1) <<< (hamd_pkg::DEG_SHIFT - 1));
        return p >>> hamd_pkg::DEG_SHIFT;
    endfunction

    function automatic longint turn_delta(longint from, longint to);
        longint d;
        d = to - from;
        if (d > hamd_pkg::HALF_TURN) d -= hamd_pkg::FULL_TURN;
        else if (d < -hamd_pkg::HALF_TURN) d += hamd_pkg::FULL_TURN;
        return d;
    endfunction

    // saturate, then drop the accumulator if its wrapped angle exceeds the limit
    function automatic longint settle_acc(longint a);
        longint w;
        a = a > hamd_pkg::ACC_MAX ? hamd_pkg::ACC_MAX
                                  : (a < hamd_pkg::ACC_MIN ? hamd_pkg::ACC_MIN : a);
        w = modulo(a + hamd_pkg::HALF_TURN, hamd_pkg::FULL_TURN) - hamd_pkg::HALF_TURN;
        if (w > hamd_pkg::ACC_LIMIT || w < -hamd_pkg::ACC_LIMIT) a = 0;
        return a;
    endfunction

    function automatic longint take_pixels(ref longint acc, input longint gain);
        longint p, px;
        p  = acc * gain;
        px = p < 0 ? -((-p) >> hamd_pkg::PIX_SHIFT) : (p >> hamd_pkg::PIX_SHIFT);
        px = clamp(px, 16);
        if (px != 0 && gain != 0) acc -= (px <<< hamd_pkg::PIX_SHIFT) / gain;
        return px;
    endfunction

    function automatic motion_t predict_motion(logic [143:0] d);
        motion_t m;
        longint yaw, pitch, dx, dy;
        yaw   = modulo(rad_to_deg(d[15:0]), hamd_pkg::FULL_TURN);
        pitch = -modulo(rad_to_deg(d[31:16]), hamd_pkg::FULL_TURN);
        if (pitch < -hamd_pkg::HALF_TURN) pitch += hamd_pkg::FULL_TURN;
        yaw_acc    = settle_acc(yaw_acc + turn_delta(prev_yaw, yaw));
        pitch_acc  = settle_acc(pitch_acc + turn_delta(prev_pitch, pitch));
        prev_yaw   = yaw;
        prev_pitch = pitch;
        dx = 0;
        dy = 0;
        if (emulation) begin
            dx = take_pixels(yaw_acc, longint'(yaw_gain));
            dy = take_pixels(pitch_acc, longint'(pitch_gain));
        end else begin
            yaw_acc   = 0;
            pitch_acc = 0;
        end
        m.move = emulation;
        m.dx   = dx[15:0];
        m.dy   = dy[15:0];
        m.ax   = 32'(clamp(longint'($signed(d[79:48])) - x_offset, 32));
        m.ay   = 32'(clamp(longint'($signed(d[111:80])) - y_offset, 32));
        m.az   = 32'(clamp(longint'($signed(d[143:112])) - z_offset, 32));
        m.ayaw = 18'(clamp(yaw - longint'(yaw_offset), 18));
        m.roll = 17'(clamp((longint'($signed(d[47:32])) * roll_gain * 292818
                            + (longint'(1) <<< 31)) >>> 32, 17));
        return m;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        motion_t want;
        if (!aresetn) begin
            emulation  <= 1'b0;
            yaw_gain   <= 16'd256;
            pitch_gain <= 16'd256;
            roll_gain  <= 16'sd256;
            yaw_offset <= '0;
            x_offset   <= '0;
            y_offset   <= '0;
            z_offset   <= '0;
            prev_yaw   = 0;
            prev_pitch = 0;
            yaw_acc    = 0;
            pitch_acc  = 0;
            motion_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (hamd_pkg::reg_index_t'(cfg_index))
                    hamd_pkg::REG_MOUSE_EMULATION: emulation  <= cfg_data[0];
                    hamd_pkg::REG_YAW_GAIN:        yaw_gain   <= cfg_data[15:0];
                    hamd_pkg::REG_PITCH_GAIN:      pitch_gain <= cfg_data[15:0];
                    hamd_pkg::REG_ROLL_GAIN:       roll_gain  <= cfg_data[15:0];
                    hamd_pkg::REG_YAW_OFFSET:      yaw_offset <= cfg_data[16:0];
                    hamd_pkg::REG_X_OFFSET:        x_offset   <= cfg_data;
                    hamd_pkg::REG_Y_OFFSET:        y_offset   <= cfg_data;
                    hamd_pkg::REG_Z_OFFSET:        z_offset   <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready && s_tuser)
                motion_q.push_back(predict_motion(s_tdata));
            if (m_tvalid && m_tready) begin
                if (motion_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = motion_q.pop_front();
                    if (m_tuser !== want.move) report_mismatch("move_valid", m_tuser, want.move);
                    if (m_tdata[15:0] !== want.dx)
                        report_mismatch("mouse_dx", $signed(m_tdata[15:0]), want.dx);
                    if (m_tdata[31:16] !== want.dy)
                        report_mismatch("mouse_dy", $signed(m_tdata[31:16]), want.dy);
                    if (m_tdata[63:32] !== want.ax)
                        report_mismatch("adjusted_x", $signed(m_tdata[63:32]), want.ax);
                    if (m_tdata[95:64] !== want.ay)
                        report_mismatch("adjusted_y", $signed(m_tdata[95:64]), want.ay);
                    if (m_tdata[127:96] !== want.az)
                        report_mismatch("adjusted_z", $signed(m_tdata[127:96]), want.az);
                    if (m_tdata[145:128] !== want.ayaw)
                        report_mismatch("adjusted_yaw", $signed(m_tdata[145:128]), want.ayaw);
                    if (m_tdata[162:146] !== want.roll)
                        report_mismatch("scaled_roll", $signed(m_tdata[162:146]), want.roll);
                    if (m_tdata[167:163] !== '0)
                        report_mismatch("pad", m_tdata[167:163], 0);
                end
            end
        end
    end

endmodule

/* tb/testbench.sv */
// Stimulus and verdict for head_angle_to_mouse_delta_top: directed and random
// tracker requests across several register settings and idle patterns.
// Depends on hamd_pkg, the design and head_angle_to_mouse_delta_checker.
`timescale 1ns / 1ps

module testbench;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid, s_tready, s_tuser;
    logic [143:0] s_tdata;
    logic         m_tvalid, m_tready, m_tuser;
    logic [167:0] m_tdata;
    logic         cfg_valid, cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;
    int           fail_count, pending;

    // idle percentages for the two sides, changed per phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // walking head pose, so most requests move the angles a little
    logic signed [15:0] yaw_now = 0, pitch_now = 0, roll_now = 0;

    head_angle_to_mouse_delta_top dut (.*);

    head_angle_to_mouse_delta_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #60_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // one request; valid is left high so back-to-back requests need no toggle
    task automatic send_sample(logic ok, logic [15:0] yaw, logic [15:0] pitch,
                               logic [15:0] roll, logic [31:0] px, logic [31:0] py,
                               logic [31:0] pz);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ok;
        s_tdata  <= {pz, py, px, roll, pitch, yaw};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // wait for the block to drain, until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(hamd_pkg::reg_index_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            yaw_now   = yaw_now + $signed(16'($urandom_range(0, 3000))) - 16'sd1500;
            pitch_now = pitch_now + $signed(16'($urandom_range(0, 3000))) - 16'sd1500;
            roll_now  = roll_now + $signed(16'($urandom_range(0, 800))) - 16'sd400;
        end else if (pick < 90) begin
            yaw_now   = 16'($urandom_range(0, 51472)) - 16'sd25736;
            pitch_now = 16'($urandom_range(0, 51472)) - 16'sd25736;
            roll_now  = 16'($urandom_range(0, 51472)) - 16'sd25736;
        end else begin
            yaw_now   = 16'($urandom);
            pitch_now = 16'($urandom);
            roll_now  = 16'($urandom);
        end
        send_sample($urandom_range(0, 9) != 0, yaw_now, pitch_now, roll_now,
                    $urandom, $urandom, $urandom);
    endtask

    initial begin
        int phase;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = hamd_pkg::REG_MOUSE_EMULATION;
        cfg_data  = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, emulation off
        send_sample(1, 16'sd25736, -16'sd25736, 16'sd25736, 32'h7fff_ffff, 32'h8000_0000, 0);
        send_sample(0, 16'h1234, 16'h4321, 16'h0f0f, 1, 2, 3);
        send_sample(1, 16'h7fff, 16'h8000, 16'h8000, 0, 0, 0);
        drain();

        // emulation on, offsets that force saturation
        write_reg(hamd_pkg::REG_MOUSE_EMULATION, 1);
        write_reg(hamd_pkg::REG_X_OFFSET, 32'h8000_0000);
        write_reg(hamd_pkg::REG_Y_OFFSET, 32'h7fff_ffff);
        write_reg(hamd_pkg::REG_Z_OFFSET, 32'hffff_ffff);
        write_reg(hamd_pkg::REG_YAW_OFFSET, 92159);
        write_reg(hamd_pkg::REG_ROLL_GAIN, 32'h0000_8000);
        send_sample(1, 0, 0, 16'sd25736, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_sample(1, 16'sd300, -16'sd300, -16'sd25736, 32'h8000_0000, 32'h7fff_ffff, 0);
        send_sample(1, 16'sd600, -16'sd600, 16'h7fff, 0, 0, 0);
        // jump past the accumulator limit, then across the wrap point
        send_sample(1, 16'sd20000, -16'sd20000, 0, 0, 0, 0);
        send_sample(1, 16'sd25000, 16'sd25000, 0, 0, 0, 0);
        send_sample(1, -16'sd25000, -16'sd25000, 0, 0, 0, 0);
        send_sample(0, 16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        drain();

        // largest gains and offset field, zero gain
        write_reg(hamd_pkg::REG_YAW_GAIN, 65535);
        write_reg(hamd_pkg::REG_PITCH_GAIN, 0);
        write_reg(hamd_pkg::REG_ROLL_GAIN, 32'h0000_7fff);
        write_reg(hamd_pkg::REG_YAW_OFFSET, 32'h1_ffff);
        send_sample(1, 16'sd100, 16'sd100, 16'sd25736, 0, 0, 0);
        send_sample(1, 16'sd900, 16'sd900, -16'sd25736, 0, 0, 0);
        send_sample(1, 16'sd1700, -16'sd700, 16'sd1, 0, 0, 0);
        send_sample(1, 16'h8000, 16'h7fff, 16'h8000, 0, 0, 0);
        // pause until every result is back before random traffic
        drain();

        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            write_reg(hamd_pkg::REG_MOUSE_EMULATION, phase != 3);
            write_reg(hamd_pkg::REG_YAW_GAIN, phase == 5 ? 1 : $urandom_range(1, 4000));
            write_reg(hamd_pkg::REG_PITCH_GAIN, phase == 6 ? 65535 : $urandom_range(1, 4000));
            write_reg(hamd_pkg::REG_ROLL_GAIN, phase == 1 ? 32'hffff_8000 : 32'($urandom));
            write_reg(hamd_pkg::REG_YAW_OFFSET, phase == 2 ? 0 : $urandom_range(0, 92159));
            write_reg(hamd_pkg::REG_X_OFFSET, $urandom);
            write_reg(hamd_pkg::REG_Y_OFFSET, phase == 4 ? 32'h8000_0000 : $urandom);
            write_reg(hamd_pkg::REG_Z_OFFSET, phase == 7 ? 32'h7fff_ffff : $urandom);
            repeat (135) random_sample();
            drain();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
